FILE: rtl/lpbrq_pkg.sv
`default_nettype none
package lpbrq_pkg;
  localparam int RING_DEPTH   = 4096;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int HEADER_BYTES = 12;
  localparam int CFG_W        = 13;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_OK_MT  = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BIG    = 3'd4,
    ST_STRAY  = 3'd5
  } status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/length_prefixed_byte_ring_queue.sv
// A payload push is answered via S_PUSH_PAY and S_OUT, a payload pull via S_PAY_RA, S_PAY_RD
// and S_OUT, and a rejected, stray or empty word goes straight to S_OUT. A message-opening push
// first makes its 12 header writes in S_HDR_W; a message-opening pull first reads the header in
// S_HDR_RA/S_HDR_RD and checks its length in S_PAY_RD. No new word is taken before the last one
// reaches the output register; one result waiting at the output does not block input.
// Reset: synchronous active-low rst_n clears pointers, counters and flags and sets the ring
// size to 4096; the ring memory itself is not cleared.
`default_nettype none
module length_prefixed_byte_ring_queue
  import lpbrq_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: opcode[0], first[1], data_byte[9:2], msg_len[21:10], flow[85:22],
  // buf_limit[97:86], zero pad [103:98]
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: status[2:0], out_byte[10:3], out_len[22:11], out_flow[86:23], pad [87]
  output logic [87:0]       out_tdata,
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // The sequencer walks a byte index through the header (0..11) and then one
  // payload step. All ring accesses share one address register and one
  // pointer-advance unit (increment with wrap at the ring size).
  typedef enum logic [2:0] {
    S_IDLE, S_HDR_W, S_HDR_RA, S_HDR_RD, S_PAY_RA, S_PAY_RD, S_PUSH_PAY, S_OUT
  } state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  ring_bytes_r;
  logic [PTR_W-1:0]  head_r, tail_r, wcur_r, rcur_r, push_left_r, pull_left_r;
  logic              dropping_r, pull_active_r;
  logic [PTR_W-1:0]  hdr_len_r;
  logic [63:0]       hdr_flow_r;
  logic [95:0]       shift_r;
  logic [3:0]        idx_r;
  logic [PTR_W-1:0]  ptr_r;
  logic [7:0]        din_r;
  logic              first_empty_r;
  logic [11:0]       limit_r;
  logic [2:0]        o_status_r;
  logic [7:0]        o_byte_r;
  logic [11:0]       o_len_r;
  logic [63:0]       o_flow_r;
  logic              o_last_r, o_valid_r;

  // Output register: holds a finished word until the receiver takes it, so the
  // sequencer can already work on the next input word.
  logic [2:0]        res_status_r;
  logic [7:0]        res_byte_r;
  logic [11:0]       res_len_r;
  logic [63:0]       res_flow_r;
  logic              res_last_r;
  logic              res_load;

  logic [7:0] mem [RING_DEPTH];
  logic [7:0] rdata_r;
  logic       we;
  logic [7:0] wdata;

  // Effective ring size saturated to [HEADER_BYTES+1, RING_DEPTH].
  logic [CFG_W:0] rsize;
  always_comb begin
    if (ring_bytes_r < CFG_W'(HEADER_BYTES + 1)) rsize = (CFG_W+1)'(HEADER_BYTES + 1);
    else if ({1'b0, ring_bytes_r} > (CFG_W+1)'(RING_DEPTH)) rsize = (CFG_W+1)'(RING_DEPTH);
    else rsize = {1'b0, ring_bytes_r};
  end

  // Shared pointer-advance unit.
  logic [PTR_W:0]   inc;
  logic [PTR_W-1:0] ptr_adv;
  always_comb begin
    inc = {1'b0, ptr_r} + (PTR_W+1)'(1);
    ptr_adv = ((CFG_W+1)'(inc) >= rsize) ? '0 : inc[PTR_W-1:0];
  end

  // Input field slices.
  logic        f_op, f_first;
  logic [7:0]  f_byte;
  logic [11:0] f_len, f_limit;
  logic [63:0] f_flow;
  assign f_op    = in_tdata[0];
  assign f_first = in_tdata[1];
  assign f_byte  = in_tdata[9:2];
  assign f_len   = in_tdata[21:10];
  assign f_flow  = in_tdata[85:22];
  assign f_limit = in_tdata[97:86];

  // Free space, computed on the first push word.
  logic [CFG_W:0] freeb, total;
  always_comb begin
    if (head_r > tail_r) freeb = (CFG_W+1)'(head_r) - (CFG_W+1)'(tail_r);
    else freeb = (CFG_W+1)'(head_r) + rsize - (CFG_W+1)'(tail_r);
    total = (CFG_W+1)'(f_len) + (CFG_W+1)'(HEADER_BYTES);
  end

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, ring_bytes_r} : '0;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = o_valid_r;
  assign out_tdata = {1'b0, res_flow_r, res_len_r, res_byte_r, res_status_r};
  assign out_tlast = res_last_r;

  // A finished word moves to the output register once that register is free.
  assign res_load = (state_r == S_OUT) && (!o_valid_r || out_tready);

  assign we = (state_r == S_HDR_W) || (state_r == S_PUSH_PAY);
  assign wdata = (state_r == S_HDR_W) ? shift_r[7:0] : din_r;

  always_ff @(posedge clk) begin
    if (we) mem[ptr_r] <= wdata;
    rdata_r <= mem[ptr_r];
  end

  logic [31:0] rd_total;
  logic [11:0] rd_dlen;
  assign rd_total = shift_r[31:0];
  assign rd_dlen = 12'(rd_total - 32'(HEADER_BYTES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ring_bytes_r <= CFG_W'(RING_DEPTH);
      head_r <= '0; tail_r <= '0; wcur_r <= '0; rcur_r <= '0;
      push_left_r <= '0; pull_left_r <= '0;
      dropping_r <= 1'b0; pull_active_r <= 1'b0;
      hdr_len_r <= '0; hdr_flow_r <= '0;
      o_valid_r <= 1'b0;
    end else if (cfg_wr) begin
      ring_bytes_r <= cfg_pwdata[CFG_W-1:0];
      head_r <= '0; tail_r <= '0; wcur_r <= '0; rcur_r <= '0;
      push_left_r <= '0; pull_left_r <= '0;
      dropping_r <= 1'b0; pull_active_r <= 1'b0;
      hdr_len_r <= '0; hdr_flow_r <= '0;
      state_r <= S_IDLE;
    end else begin
      if (res_load) o_valid_r <= 1'b1;
      else if (o_valid_r && out_tready) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            o_byte_r <= '0; o_last_r <= 1'b0;
            din_r <= f_byte;
            limit_r <= f_limit;
            if (f_op == OP_PUSH) begin
              o_len_r <= '0; o_flow_r <= '0;
              if (f_first) begin
                if (freeb <= total) begin
                  push_left_r <= '0;
                  dropping_r <= 1'b1;
                  o_status_r <= ST_FULL;
                  state_r <= S_OUT;
                end else begin
                  dropping_r <= 1'b0;
                  first_empty_r <= (freeb == rsize);
                  shift_r <= {f_flow, 32'(total)};
                  push_left_r <= f_len;
                  ptr_r <= tail_r;
                  idx_r <= '0;
                  state_r <= S_HDR_W;
                end
              end else if (dropping_r) begin
                o_status_r <= ST_FULL; state_r <= S_OUT;
              end else if (push_left_r == '0) begin
                o_status_r <= ST_STRAY; state_r <= S_OUT;
              end else begin
                o_status_r <= ST_OK;
                ptr_r <= wcur_r;
                state_r <= S_PUSH_PAY;
              end
            end else begin
              if (pull_active_r) begin
                o_status_r <= ST_OK;
                o_len_r <= hdr_len_r; o_flow_r <= hdr_flow_r;
                ptr_r <= rcur_r;
                state_r <= S_PAY_RA;
              end else if (head_r == tail_r) begin
                o_status_r <= ST_EMPTY;
                o_len_r <= '0; o_flow_r <= '0;
                state_r <= S_OUT;
              end else begin
                o_status_r <= ST_OK;
                ptr_r <= head_r; idx_r <= '0;
                state_r <= S_HDR_RA;
              end
            end
          end
        end
        S_HDR_W: begin
          shift_r <= {8'h00, shift_r[95:8]};
          ptr_r <= ptr_adv;
          idx_r <= idx_r + 4'd1;
          if (idx_r == 4'(HEADER_BYTES - 1)) begin
            wcur_r <= ptr_adv;
            o_status_r <= first_empty_r ? ST_OK_MT : ST_OK;
            if (push_left_r == '0) begin
              tail_r <= ptr_adv; state_r <= S_OUT;
            end else begin
              state_r <= S_PUSH_PAY;
            end
          end
        end
        S_PUSH_PAY: begin
          wcur_r <= ptr_adv;
          push_left_r <= push_left_r - PTR_W'(1);
          if (push_left_r == PTR_W'(1)) tail_r <= ptr_adv;
          state_r <= S_OUT;
        end
        S_HDR_RA: begin
          state_r <= S_HDR_RD;
        end
        S_HDR_RD: begin
          shift_r <= {rdata_r, shift_r[95:8]};
          ptr_r <= ptr_adv;
          idx_r <= idx_r + 4'd1;
          // After the last header byte the length check happens in S_PAY_RD.
          if (idx_r == 4'(HEADER_BYTES - 1)) state_r <= S_PAY_RD;
          else state_r <= S_HDR_RA;
        end
        S_PAY_RA: begin
          state_r <= S_PAY_RD;
        end
        S_PAY_RD: begin
          if (!pull_active_r && idx_r == 4'(HEADER_BYTES)) begin
            // Header was just read; ptr_r holds the first payload address.
            idx_r <= '0;
            o_len_r <= rd_dlen;
            o_flow_r <= shift_r[95:32];
            if (rd_dlen > limit_r) begin
              o_status_r <= ST_BIG; state_r <= S_OUT;
            end else begin
              hdr_len_r <= rd_dlen; hdr_flow_r <= shift_r[95:32];
              rcur_r <= ptr_r;
              pull_left_r <= rd_dlen;
              if (rd_dlen == '0) begin
                head_r <= ptr_r; o_last_r <= 1'b1; state_r <= S_OUT;
              end else begin
                pull_active_r <= 1'b1;
                state_r <= S_PAY_RA;
              end
            end
          end else begin
            o_byte_r <= rdata_r;
            rcur_r <= ptr_adv;
            pull_left_r <= pull_left_r - PTR_W'(1);
            if (pull_left_r == PTR_W'(1)) begin
              head_r <= ptr_adv; pull_active_r <= 1'b0; o_last_r <= 1'b1;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res_status_r <= o_status_r;
            res_byte_r <= o_byte_r;
            res_len_r <= o_len_r;
            res_flow_r <= o_flow_r;
            res_last_r <= o_last_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
